/* hw/rtl/rbsi_pkg.sv */
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types and constants for the ray / box slab intersection pipeline
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int FRAC_BITS       = 16;
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;

    // slab divider: 49-bit dividend magnitude by 32-bit divisor magnitude
    localparam int DIV_QW     = DATA_W;
    localparam int DIV_NW     = DATA_W + 1 + FRAC_BITS;
    localparam int DIV_HW     = DIV_NW - DIV_QW;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = DIV_QW / DIV_STAGES;

    // setup, divider, slab select, combine, multiply, output
    localparam int STAGE_CNT = DIV_STAGES + 5;

    localparam int IN_FIELDS = 12;
    localparam int IN_W      = IN_FIELDS * DATA_W;
    localparam int OUT_W     = 136;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [DIV_NW-1:0]        num_t;
    typedef logic [DIV_QW-1:0]        den_t;

    typedef struct packed {
        logic zero;
        logic spec_pos;
        logic qneg;
    } slab_flag_t;

    typedef struct packed {
        coord_t     [2:0] o;
        coord_t     [2:0] d;
        slab_flag_t [5:0] fl;
    } side_t;

endpackage

/* hw/rtl/rbsi_setup.sv */
// ----------------------------------------------------------------------------
// rbsi_setup
// sign extension, near / far bound select and divider operand forming
// ----------------------------------------------------------------------------
module rbsi_setup
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  coord_t [IN_FIELDS-1:0] fields,
    output num_t   [5:0]           num,
    output den_t   [5:0]           den,
    output side_t                  side
);

    localparam int CW = (COORD_WIDTH > DATA_W) ? DATA_W : COORD_WIDTH;
    localparam int SH = DATA_W - CW;

    coord_t [IN_FIELDS-1:0] sx;

    always_comb
    begin
        for (int i = 0; i < IN_FIELDS; i++)
        begin
            sx[i] = coord_t'($signed(fields[i] << SH) >>> SH);
        end
    end

    always_comb
    begin
        coord_t                  o;
        coord_t                  d;
        coord_t                  bnd;
        logic                    neg;
        logic signed [DATA_W:0]  diff;
        logic [DATA_W:0]         amag;
        den_t                    dmag;
        side = '0;
        num  = '0;
        den  = '0;
        for (int a = 0; a < 3; a++)
        begin
            o    = sx[a];
            d    = sx[3 + a];
            neg  = d[DATA_W-1];
            dmag = neg ? den_t'(-d) : den_t'(d);
            side.o[a] = o;
            side.d[a] = d;
            for (int n = 0; n < 2; n++)
            begin
                bnd  = (neg ^ (n == 1)) ? sx[9 + a] : sx[6 + a];
                diff = {bnd[DATA_W-1], bnd} - {o[DATA_W-1], o};
                amag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
                num[2*a + n] = {amag, {FRAC_BITS{1'b0}}};
                den[2*a + n] = dmag;
                side.fl[2*a + n].zero     = (d == '0);
                side.fl[2*a + n].spec_pos = (!diff[DATA_W] && (diff != '0))
                                            || ((diff == '0) && (n == 1));
                side.fl[2*a + n].qneg     = diff[DATA_W] ^ neg;
            end
        end
    end

endmodule

/* hw/rtl/rbsi_div.sv */
// ----------------------------------------------------------------------------
// rbsi_div
// pipelined restoring divider, a few quotient bits per stage, with overflow
// ----------------------------------------------------------------------------
module rbsi_div
    import rbsi_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  num_t                  num,
    input  den_t                  den,
    output logic [DIV_QW-1:0]     q,
    output logic                  ovf
);

    logic [DIV_STAGES-1:0][DIV_QW-1:0] rem_reg;
    logic [DIV_STAGES-1:0][DIV_QW-1:0] low_reg;
    den_t [DIV_STAGES-1:0]             den_reg;
    logic [DIV_STAGES-1:0]             ovf_reg;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [DIV_QW-1:0] rem_in;
        logic [DIV_QW-1:0] low_in;
        logic [DIV_QW-1:0] rem_next;
        logic [DIV_QW-1:0] low_next;
        den_t              den_next;
        logic              ovf_next;

        if (s == 0)
        begin : g_first
            assign rem_in   = DIV_QW'(num[DIV_NW-1:DIV_QW]);
            assign low_in   = num[DIV_QW-1:0];
            assign den_next = den;
            assign ovf_next = (DIV_QW'(num[DIV_NW-1:DIV_QW]) >= den);
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[s-1];
            assign low_in   = low_reg[s-1];
            assign den_next = den_reg[s-1];
            assign ovf_next = ovf_reg[s-1];
        end

        always_comb
        begin
            logic [DIV_QW:0]   r;
            logic [DIV_QW-1:0] rm;
            logic [DIV_QW-1:0] lw;
            logic              b;
            rm = rem_in;
            lw = low_in;
            for (int i = 0; i < DIV_BITS; i++)
            begin
                r = {rm, lw[DIV_QW-1]};
                b = (r >= {1'b0, den_next});
                if (b)
                begin
                    rm = DIV_QW'(r - {1'b0, den_next});
                end
                else
                begin
                    rm = r[DIV_QW-1:0];
                end
                lw = {lw[DIV_QW-2:0], b};
            end
            rem_next = rm;
            low_next = lw;
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next;
                low_reg[s] <= low_next;
                den_reg[s] <= den_next;
                ovf_reg[s] <= ovf_next;
            end
        end
    end

    assign q   = low_reg[DIV_STAGES-1];
    assign ovf = ovf_reg[DIV_STAGES-1];

endmodule

/* hw/rtl/rbsi_slab_comb.sv */
// ----------------------------------------------------------------------------
// rbsi_slab_comb
// slab parameter saturation and per-axis interval combine into a hit flag
// ----------------------------------------------------------------------------
module rbsi_slab_comb
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic [1:0]             en,
    input  logic [5:0][DIV_QW-1:0] q,
    input  logic [5:0]             ovf,
    input  side_t                  side,
    output logic                   hit,
    output coord_t                 tmin,
    output coord_t [2:0]           o,
    output coord_t [2:0]           d
);

    localparam int CW = (COORD_WIDTH > DATA_W) ? DATA_W : COORD_WIDTH;
    localparam logic signed [63:0] TMAX_L = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] TMIN_L = -TMAX_L - 64'sd1;

    coord_t [5:0] t_next;
    coord_t [5:0] t_reg;
    coord_t [2:0] o1_reg;
    coord_t [2:0] d1_reg;

    logic   hit_next;
    coord_t tmin_next;
    logic   hit_reg;
    coord_t tmin_reg;
    coord_t [2:0] o2_reg;
    coord_t [2:0] d2_reg;

    always_comb
    begin
        logic signed [63:0] sv;
        for (int j = 0; j < 6; j++)
        begin
            sv = side.fl[j].qneg ? -$signed({32'b0, q[j]}) : $signed({32'b0, q[j]});
            if (side.fl[j].zero)
            begin
                t_next[j] = side.fl[j].spec_pos ? coord_t'(TMAX_L) : coord_t'(-TMAX_L);
            end
            else if (ovf[j] || (sv > TMAX_L) || (sv < TMIN_L))
            begin
                t_next[j] = side.fl[j].qneg ? coord_t'(TMIN_L) : coord_t'(TMAX_L);
            end
            else
            begin
                t_next[j] = coord_t'(sv);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg  <= t_next;
            o1_reg <= side.o;
            d1_reg <= side.d;
        end
    end

    always_comb
    begin
        coord_t lo;
        coord_t hi;
        logic   ok;
        lo = t_reg[0];
        hi = t_reg[1];
        ok = 1'b1;
        for (int a = 1; a < 3; a++)
        begin
            if ((lo > t_reg[2*a + 1]) || (t_reg[2*a] > hi))
            begin
                ok = 1'b0;
            end
            if (t_reg[2*a] > lo)
            begin
                lo = t_reg[2*a];
            end
            if (t_reg[2*a + 1] < hi)
            begin
                hi = t_reg[2*a + 1];
            end
        end
        hit_next  = ok && (lo < ONE_Q) && (hi > 0);
        tmin_next = lo;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hit_reg  <= hit_next;
            tmin_reg <= tmin_next;
            o2_reg   <= o1_reg;
            d2_reg   <= d1_reg;
        end
    end

    assign hit  = hit_reg;
    assign tmin = tmin_reg;
    assign o    = o2_reg;
    assign d    = d2_reg;

endmodule

/* hw/rtl/rbsi_hitpos.sv */
// ----------------------------------------------------------------------------
// rbsi_hitpos
// hit point origin + dir * t, floored to q16.16 and saturated
// ----------------------------------------------------------------------------
module rbsi_hitpos
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic [1:0]   en,
    input  logic         hit_in,
    input  coord_t       tmin,
    input  coord_t [2:0] o,
    input  coord_t [2:0] d,
    output logic         hit,
    output coord_t       entry,
    output coord_t [2:0] pos
);

    localparam int CW = (COORD_WIDTH > DATA_W) ? DATA_W : COORD_WIDTH;
    localparam logic signed [63:0] TMAX_L = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] TMIN_L = -TMAX_L - 64'sd1;

    logic signed [2:0][63:0] prod_reg;
    coord_t [2:0]            o_reg;
    logic                    hit1_reg;
    coord_t                  tmin_reg;

    logic                    hit_reg;
    coord_t                  entry_reg;
    coord_t [2:0]            pos_reg;
    coord_t [2:0]            pos_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= 64'(d[a]) * 64'(tmin);
            end
            o_reg    <= o;
            hit1_reg <= hit_in;
            tmin_reg <= tmin;
        end
    end

    always_comb
    begin
        logic signed [63:0] s;
        for (int a = 0; a < 3; a++)
        begin
            s = ($signed(prod_reg[a]) >>> FRAC_BITS) + 64'(o_reg[a]);
            if (!hit1_reg)
            begin
                pos_next[a] = '0;
            end
            else if (s > TMAX_L)
            begin
                pos_next[a] = coord_t'(TMAX_L);
            end
            else if (s < TMIN_L)
            begin
                pos_next[a] = coord_t'(TMIN_L);
            end
            else
            begin
                pos_next[a] = coord_t'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hit_reg   <= hit1_reg;
            entry_reg <= hit1_reg ? tmin_reg : '0;
            pos_reg   <= pos_next;
        end
    end

    assign hit   = hit_reg;
    assign entry = entry_reg;
    assign pos   = pos_reg;

endmodule

/* hw/rtl/ray_box_slab_intersect.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// ray segment against axis-aligned box, slab test in signed q16.16
// ----------------------------------------------------------------------------
// Fully pipelined: one ray/box item is taken every clock while s_tready is
// high, and its result passes through operand setup, an 8-stage divider doing
// 4 quotient bits per stage for the six slab parameters, slab saturation,
// interval combine, the hit-point multiply and the output register. Every
// stage holds its item under backpressure and bubbles are squeezed out, so the
// input keeps moving while a finished result waits, until every stage is full.
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, box_min_x/y/z, box_max_x/y/z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit, entry_distance, hit_pos_x, hit_pos_y, hit_pos_z, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    logic [STAGE_CNT-1:0] valid_reg;
    logic [STAGE_CNT-1:0] valid_next;
    logic [STAGE_CNT:0]   adv;

    coord_t [IN_FIELDS-1:0] fields;
    num_t   [5:0]           num_next;
    den_t   [5:0]           den_next;
    side_t                  side_next;

    num_t  [5:0]            num_reg;
    den_t  [5:0]            den_reg;
    side_t [DIV_STAGES:0]   side_reg;

    logic [5:0][DIV_QW-1:0] q;
    logic [5:0]             ovf;

    logic         c_hit;
    coord_t       c_tmin;
    coord_t [2:0] c_o;
    coord_t [2:0] c_d;

    logic         r_hit;
    coord_t       r_entry;
    coord_t [2:0] r_pos;

    always_comb
    begin
        adv[STAGE_CNT] = m_tready;
        for (int k = STAGE_CNT - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGE_CNT; k++)
        begin
            if (!adv[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = s_tvalid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGE_CNT-1];

    always_comb
    begin
        for (int i = 0; i < IN_FIELDS; i++)
        begin
            fields[i] = s_tdata[DATA_W*i +: DATA_W];
        end
    end

    rbsi_setup #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_setup (
        .fields (fields),
        .num    (num_next),
        .den    (den_next),
        .side   (side_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            num_reg     <= num_next;
            den_reg     <= den_next;
            side_reg[0] <= side_next;
        end
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar j = 0; j < 6; j++)
    begin : g_div
        rbsi_div u_div (
            .clk (clk),
            .en  (adv[DIV_STAGES:1]),
            .num (num_reg[j]),
            .den (den_reg[j]),
            .q   (q[j]),
            .ovf (ovf[j])
        );
    end

    rbsi_slab_comb #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_comb (
        .clk  (clk),
        .en   (adv[DIV_STAGES+2:DIV_STAGES+1]),
        .q    (q),
        .ovf  (ovf),
        .side (side_reg[DIV_STAGES]),
        .hit  (c_hit),
        .tmin (c_tmin),
        .o    (c_o),
        .d    (c_d)
    );

    rbsi_hitpos #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_hitpos (
        .clk    (clk),
        .en     (adv[DIV_STAGES+4:DIV_STAGES+3]),
        .hit_in (c_hit),
        .tmin   (c_tmin),
        .o      (c_o),
        .d      (c_d),
        .hit    (r_hit),
        .entry  (r_entry),
        .pos    (r_pos)
    );

    assign m_tdata = {7'b0, r_pos[2], r_pos[1], r_pos[0], r_entry, r_hit};

endmodule

/* hw/rtl/rbsi_checker.sv */
// ----------------------------------------------------------------------------
// rbsi_checker
// port-level checks for the slab intersection pipeline, bound to the top
// ----------------------------------------------------------------------------
module rbsi_checker
    import rbsi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // offered input item stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item dropped or changed while waiting");

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item dropped or changed under stall");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[128:1] == '0))
        else $error("miss item with nonzero fields");

    // a hit enters before the end of the segment
    a_hit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> ($signed(m_tdata[32:1]) < ONE_Q))
        else $error("hit item with entry at or past segment end");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_W-1:129] == '0))
        else $error("nonzero padding in output item");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
